// ----- sv/i2cram_pkg.sv -----
package i2cram_pkg;

  localparam int MAX_BURST_DEF = 255;

  // command codes carried on the action field
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_BYTE  = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_ADDR      = 4'd2,
    PH_ADDR_ACK  = 4'd3,
    PH_REG       = 4'd4,
    PH_REG_ACK   = 4'd5,
    PH_WAIT      = 4'd6,
    PH_DATA      = 4'd7,
    PH_DATA_ACK  = 4'd8,
    PH_RSTART    = 4'd9,
    PH_RADDR     = 4'd10,
    PH_RADDR_ACK = 4'd11,
    PH_RECV      = 4'd12,
    PH_MACK      = 4'd13,
    PH_STOP      = 4'd14
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       want_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       ack_sampled;
    logic       ack_valid;
    logic       done_res;
  } out_t;

  // sequencer state
  typedef struct packed {
    phase_t     phase;
    logic [2:0] bit_index;
    logic [1:0] substep;
    logic [7:0] send_shift;
    logic [7:0] receive_shift;
    logic [7:0] bytes_left;
    logic [6:0] target_device;
    logic [7:0] target_register;
    logic       read_mode;
    logic       byte_pending;
    logic       scl_level;
    logic       sda_level;
  } st_t;

endpackage

// ----- sv/i2cram_step.sv -----
module i2cram_step #(
  parameter int MAX_BURST = i2cram_pkg::MAX_BURST_DEF
) (
  input  i2cram_pkg::st_t  st_i,
  input  i2cram_pkg::in_t  in_i,
  output i2cram_pkg::st_t  st_o,
  output i2cram_pkg::out_t res_o
);

  localparam logic [7:0] MaxBurstW = 8'(MAX_BURST);

  function automatic i2cram_pkg::st_t enter_ph(i2cram_pkg::st_t s, i2cram_pkg::phase_t ph);
    i2cram_pkg::st_t r;
    r = s;
    r.phase = ph;
    r.substep = 2'd0;
    r.bit_index = 3'd0;
    return r;
  endfunction

  // one bit of a sent byte
  function automatic i2cram_pkg::st_t send_step(i2cram_pkg::st_t s, output logic fin);
    i2cram_pkg::st_t r;
    r = s;
    fin = 1'b0;
    case (s.substep)
      2'd0: begin
        r.sda_level = s.send_shift[3'd7 - s.bit_index];
        r.substep = 2'd1;
      end
      2'd1: begin
        r.scl_level = 1'b1;
        r.substep = 2'd2;
      end
      default: begin
        r.scl_level = 1'b0;
        r.substep = 2'd0;
        if (s.bit_index == 3'd7) begin
          r.bit_index = 3'd0;
          fin = 1'b1;
        end else begin
          r.bit_index = s.bit_index + 3'd1;
        end
      end
    endcase
    return r;
  endfunction

  // acknowledge read from the device
  function automatic i2cram_pkg::st_t ack_step(i2cram_pkg::st_t s, output logic fin);
    i2cram_pkg::st_t r;
    r = s;
    fin = 1'b0;
    case (s.substep)
      2'd0: begin
        r.sda_level = 1'b1;
        r.substep = 2'd1;
      end
      2'd1: begin
        r.scl_level = 1'b1;
        r.substep = 2'd2;
      end
      default: begin
        r.scl_level = 1'b0;
        r.substep = 2'd0;
        fin = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic i2cram_pkg::st_t start_step(i2cram_pkg::st_t s, output logic fin);
    i2cram_pkg::st_t r;
    r = s;
    fin = 1'b0;
    case (s.substep)
      2'd0: begin
        r.sda_level = 1'b1;
        r.substep = 2'd1;
      end
      2'd1: begin
        r.scl_level = 1'b1;
        r.substep = 2'd2;
      end
      2'd2: begin
        r.sda_level = 1'b0;
        r.substep = 2'd3;
      end
      default: begin
        r.scl_level = 1'b0;
        r.substep = 2'd0;
        fin = 1'b1;
      end
    endcase
    return r;
  endfunction

  i2cram_pkg::st_t s;
  logic            fin;
  logic            run;
  logic            ack_hit;
  logic            rd_hit;
  logic            last_hit;
  logic            done_hit;
  logic [7:0]      cnt;
  logic [7:0]      left_dec;

  always_comb begin
    s        = st_i;
    fin      = 1'b0;
    run      = 1'b0;
    ack_hit  = 1'b0;
    rd_hit   = 1'b0;
    last_hit = 1'b0;
    done_hit = 1'b0;
    left_dec = 8'd0;
    cnt      = (in_i.byte_count > MaxBurstW) ? MaxBurstW : in_i.byte_count;

    case (i2cram_pkg::act_t'(in_i.action))
      i2cram_pkg::ACT_TICK: begin
        run = 1'b1;
        if (s.phase == i2cram_pkg::PH_WAIT) begin
          if (!s.byte_pending) begin
            run = 1'b0;
          end else begin
            s.byte_pending = 1'b0;
            s = enter_ph(s, i2cram_pkg::PH_DATA);
          end
        end
        if (run) begin
          case (s.phase)
            i2cram_pkg::PH_START: begin
              s = start_step(s, fin);
              if (fin) begin
                s = enter_ph(s, i2cram_pkg::PH_ADDR);
                s.send_shift = {s.target_device, 1'b0};
              end
            end
            i2cram_pkg::PH_ADDR: begin
              s = send_step(s, fin);
              if (fin) s = enter_ph(s, i2cram_pkg::PH_ADDR_ACK);
            end
            i2cram_pkg::PH_ADDR_ACK: begin
              s = ack_step(s, fin);
              ack_hit = fin;
              if (fin) begin
                s = enter_ph(s, i2cram_pkg::PH_REG);
                s.send_shift = s.target_register;
              end
            end
            i2cram_pkg::PH_REG: begin
              s = send_step(s, fin);
              if (fin) s = enter_ph(s, i2cram_pkg::PH_REG_ACK);
            end
            i2cram_pkg::PH_REG_ACK: begin
              s = ack_step(s, fin);
              ack_hit = fin;
              if (fin) begin
                if (s.read_mode) s = enter_ph(s, i2cram_pkg::PH_RSTART);
                else if (s.bytes_left != 8'd0) s = enter_ph(s, i2cram_pkg::PH_WAIT);
                else s = enter_ph(s, i2cram_pkg::PH_STOP);
              end
            end
            i2cram_pkg::PH_DATA: begin
              s = send_step(s, fin);
              if (fin) s = enter_ph(s, i2cram_pkg::PH_DATA_ACK);
            end
            i2cram_pkg::PH_DATA_ACK: begin
              s = ack_step(s, fin);
              ack_hit = fin;
              if (fin) begin
                if (s.bytes_left != 8'd0) left_dec = s.bytes_left - 8'd1;
                s.bytes_left = left_dec;
                if (left_dec != 8'd0) s = enter_ph(s, i2cram_pkg::PH_WAIT);
                else s = enter_ph(s, i2cram_pkg::PH_STOP);
              end
            end
            i2cram_pkg::PH_RSTART: begin
              s = start_step(s, fin);
              if (fin) begin
                s = enter_ph(s, i2cram_pkg::PH_RADDR);
                s.send_shift = {s.target_device, 1'b1};
              end
            end
            i2cram_pkg::PH_RADDR: begin
              s = send_step(s, fin);
              if (fin) s = enter_ph(s, i2cram_pkg::PH_RADDR_ACK);
            end
            i2cram_pkg::PH_RADDR_ACK: begin
              s = ack_step(s, fin);
              ack_hit = fin;
              if (fin) begin
                if (s.bytes_left != 8'd0) s = enter_ph(s, i2cram_pkg::PH_RECV);
                else s = enter_ph(s, i2cram_pkg::PH_STOP);
              end
            end
            i2cram_pkg::PH_RECV: begin
              case (s.substep)
                2'd0: begin
                  s.sda_level = 1'b1;
                  s.receive_shift = 8'd0;
                  s.bit_index = 3'd0;
                  s.substep = 2'd1;
                end
                2'd1: begin
                  s.scl_level = 1'b1;
                  s.substep = 2'd2;
                end
                default: begin
                  if (in_i.sda_in) s.receive_shift[3'd7 - s.bit_index] = 1'b1;
                  s.scl_level = 1'b0;
                  if (s.bit_index == 3'd7) begin
                    rd_hit   = 1'b1;
                    last_hit = (s.bytes_left == 8'd1);
                    s = enter_ph(s, i2cram_pkg::PH_MACK);
                  end else begin
                    s.bit_index = s.bit_index + 3'd1;
                    s.substep = 2'd1;
                  end
                end
              endcase
            end
            i2cram_pkg::PH_MACK: begin
              case (s.substep)
                2'd0: begin
                  s.sda_level = (s.bytes_left <= 8'd1);
                  s.substep = 2'd1;
                end
                2'd1: begin
                  s.scl_level = 1'b1;
                  s.substep = 2'd2;
                end
                default: begin
                  s.scl_level = 1'b0;
                  if (s.bytes_left != 8'd0) left_dec = s.bytes_left - 8'd1;
                  s.bytes_left = left_dec;
                  if (left_dec != 8'd0) s = enter_ph(s, i2cram_pkg::PH_RECV);
                  else s = enter_ph(s, i2cram_pkg::PH_STOP);
                end
              endcase
            end
            i2cram_pkg::PH_STOP: begin
              case (s.substep)
                2'd0: begin
                  s.sda_level = 1'b0;
                  s.substep = 2'd1;
                end
                2'd1: begin
                  s.scl_level = 1'b1;
                  s.substep = 2'd2;
                end
                default: begin
                  s.sda_level = 1'b1;
                  done_hit = 1'b1;
                  s = enter_ph(s, i2cram_pkg::PH_IDLE);
                end
              endcase
            end
            default: begin
              s = enter_ph(s, i2cram_pkg::PH_IDLE);
            end
          endcase
        end
      end
      i2cram_pkg::ACT_BYTE: begin
        if (s.phase == i2cram_pkg::PH_WAIT) begin
          s.send_shift = in_i.write_data;
          s.byte_pending = 1'b1;
        end
      end
      default: begin
        // begin write or begin read, taken only when idle
        if (s.phase == i2cram_pkg::PH_IDLE) begin
          s.target_device   = in_i.device_address;
          s.target_register = in_i.register_address;
          s.bytes_left      = cnt;
          s.read_mode       = (in_i.action == i2cram_pkg::ACT_READ);
          s.byte_pending    = 1'b0;
          s = enter_ph(s, i2cram_pkg::PH_START);
        end
      end
    endcase
  end

  assign st_o = s;

  always_comb begin
    res_o.scl_out     = s.scl_level;
    res_o.sda_out     = s.sda_level;
    res_o.busy_res    = (s.phase != i2cram_pkg::PH_IDLE);
    res_o.want_byte   = (s.phase == i2cram_pkg::PH_WAIT) && !s.byte_pending;
    res_o.read_data   = rd_hit ? s.receive_shift : 8'd0;
    res_o.read_valid  = rd_hit;
    res_o.read_last   = last_hit;
    res_o.ack_sampled = ack_hit & in_i.sda_in;
    res_o.ack_valid   = ack_hit;
    res_o.done_res    = done_hit;
  end

endmodule

// ----- sv/i2cram_obuf.sv -----
module i2cram_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  i2cram_pkg::out_t push_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cram_pkg::out_t out_data
);

  logic             main_v_r;
  logic             main_v_nxt;
  logic             skid_v_r;
  logic             skid_v_nxt;
  i2cram_pkg::out_t main_d_r;
  i2cram_pkg::out_t main_d_nxt;
  i2cram_pkg::out_t skid_d_r;
  i2cram_pkg::out_t skid_d_nxt;
  logic             pop;

  assign pop       = main_v_r && out_ready;
  assign room      = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    main_d_nxt = main_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (pop) begin
        main_d_nxt = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push && main_v_r && !pop) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end else if (push) begin
      main_v_nxt = 1'b1;
      main_d_nxt = push_data;
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

// ----- sv/i2c_register_access_master.sv -----
// result: an accepted beat's result is registered in the result register or skid
// throughput: one beat per cycle; the input stalls only when the result
//   register and its skid stage both hold beats not yet taken
// reset: synchronous, active low; sequencer returns to idle with scl and sda
//   released high, both result slots emptied
module i2c_register_access_master #(
  parameter int MAX_BURST = i2cram_pkg::MAX_BURST_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2cram_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cram_pkg::out_t out_data
);

  // sequencer state: start, address, register, data or repeated start and
  // receive, stop; every accepted beat advances it by at most one pin step
  i2cram_pkg::st_t  st_r;
  i2cram_pkg::st_t  st_nxt;
  i2cram_pkg::out_t res_nxt;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  // one pin step worth of logic, from current state and the incoming beat
  i2cram_step #(
    .MAX_BURST (MAX_BURST)
  ) u_step (
    .st_i  (st_r),
    .in_i  (in_data),
    .st_o  (st_nxt),
    .res_o (res_nxt)
  );

  // state commits only when a beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase           <= i2cram_pkg::PH_IDLE;
      st_r.bit_index       <= 3'd0;
      st_r.substep         <= 2'd0;
      st_r.send_shift      <= 8'd0;
      st_r.receive_shift   <= 8'd0;
      st_r.bytes_left      <= 8'd0;
      st_r.target_device   <= 7'd0;
      st_r.target_register <= 8'd0;
      st_r.read_mode       <= 1'b0;
      st_r.byte_pending    <= 1'b0;
      st_r.scl_level       <= 1'b1;
      st_r.sda_level       <= 1'b1;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register plus skid slot, so input keeps flowing under a short stall
  i2cram_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res_nxt),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a pending write byte only exists while waiting for one
  a_pending_in_wait : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_pending |-> (st_r.phase == i2cram_pkg::PH_WAIT))
    else $error("byte pending outside wait phase");

  // idle always has its step counters cleared
  a_idle_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == i2cram_pkg::PH_IDLE) |-> (st_r.substep == 2'd0 && st_r.bit_index == 3'd0))
    else $error("idle with stale step counters");

  // finishing stop leaves the sequencer idle with lines released
  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.done_res) |=>
      (st_r.phase == i2cram_pkg::PH_IDLE && st_r.scl_level && st_r.sda_level))
    else $error("stop finished but sequencer not idle");

  // a completed received byte can only come from the receive phase
  a_rd_from_recv : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.read_valid) |-> (st_r.phase == i2cram_pkg::PH_RECV))
    else $error("read byte reported outside receive phase");

endmodule

// ----- tb/i2c_register_access_master_check.sv -----
`timescale 1ns / 1ps
module i2c_register_access_master_check #(
  parameter int MAX_BURST = i2cram_pkg::MAX_BURST_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  i2cram_pkg::in_t  in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  i2cram_pkg::out_t out_data,
  output int               fail_count,
  output int               waiting,
  output int               checked_count,
  output int               stop_count,
  output int               rx_byte_count
);

  // shadow of the pin sequencer
  i2cram_pkg::phase_t seq_phase;
  logic [2:0]         bit_pos;
  logic [1:0]         sub_step;
  logic [7:0]         tx_shift;
  logic [7:0]         rx_shift;
  logic [7:0]         bytes_to_go;
  logic [6:0]         dev_addr;
  logic [7:0]         reg_sel;
  logic               rd_mode;
  logic               tx_loaded;
  logic               scl_lvl;
  logic               sda_lvl;
  i2cram_pkg::out_t   step_flags;

  i2cram_pkg::out_t line_states[$];
  int   fails = 0;
  int   checks = 0;
  int   stops = 0;
  int   rx_bytes = 0;

  function automatic void goto_phase(i2cram_pkg::phase_t p);
    seq_phase = p;
    sub_step  = 2'd0;
    bit_pos   = 3'd0;
  endfunction

  function automatic void clear_sequencer();
    goto_phase(i2cram_pkg::PH_IDLE);
    tx_shift    = '0;
    rx_shift    = '0;
    bytes_to_go = '0;
    dev_addr    = '0;
    reg_sel     = '0;
    rd_mode     = 1'b0;
    tx_loaded   = 1'b0;
    scl_lvl     = 1'b1;
    sda_lvl     = 1'b1;
  endfunction

  // one bit of a sent byte, true once the byte is out
  function automatic bit send_bit_step();
    send_bit_step = 1'b0;
    case (sub_step)
      2'd0: begin
        sda_lvl  = tx_shift[7 - bit_pos];
        sub_step = 2'd1;
      end
      2'd1: begin
        scl_lvl  = 1'b1;
        sub_step = 2'd2;
      end
      default: begin
        scl_lvl  = 1'b0;
        sub_step = 2'd0;
        if (bit_pos == 3'd7) begin
          bit_pos       = 3'd0;
          send_bit_step = 1'b1;
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
    endcase
  endfunction

  // slave acknowledge slot, true once sampled
  function automatic bit ack_slot_step(logic sda);
    ack_slot_step = 1'b0;
    case (sub_step)
      2'd0: begin
        sda_lvl  = 1'b1;
        sub_step = 2'd1;
      end
      2'd1: begin
        scl_lvl  = 1'b1;
        sub_step = 2'd2;
      end
      default: begin
        step_flags.ack_sampled = sda;
        step_flags.ack_valid   = 1'b1;
        scl_lvl       = 1'b0;
        sub_step      = 2'd0;
        ack_slot_step = 1'b1;
      end
    endcase
  endfunction

  function automatic bit start_cond_step();
    start_cond_step = 1'b0;
    case (sub_step)
      2'd0: begin sda_lvl = 1'b1; sub_step = 2'd1; end
      2'd1: begin scl_lvl = 1'b1; sub_step = 2'd2; end
      2'd2: begin sda_lvl = 1'b0; sub_step = 2'd3; end
      default: begin
        scl_lvl         = 1'b0;
        sub_step        = 2'd0;
        start_cond_step = 1'b1;
      end
    endcase
  endfunction

  function automatic void after_write_ack();
    if (bytes_to_go != 8'd0) goto_phase(i2cram_pkg::PH_WAIT);
    else goto_phase(i2cram_pkg::PH_STOP);
  endfunction

  function automatic void pin_tick(logic sda);
    if (seq_phase == i2cram_pkg::PH_WAIT) begin
      if (!tx_loaded) return;
      tx_loaded = 1'b0;
      goto_phase(i2cram_pkg::PH_DATA);
    end
    case (seq_phase)
      i2cram_pkg::PH_START: begin
        if (start_cond_step()) begin
          goto_phase(i2cram_pkg::PH_ADDR);
          tx_shift = {dev_addr, 1'b0};
        end
      end
      i2cram_pkg::PH_ADDR: if (send_bit_step()) goto_phase(i2cram_pkg::PH_ADDR_ACK);
      i2cram_pkg::PH_ADDR_ACK: begin
        if (ack_slot_step(sda)) begin
          goto_phase(i2cram_pkg::PH_REG);
          tx_shift = reg_sel;
        end
      end
      i2cram_pkg::PH_REG: if (send_bit_step()) goto_phase(i2cram_pkg::PH_REG_ACK);
      i2cram_pkg::PH_REG_ACK: begin
        if (ack_slot_step(sda)) begin
          if (rd_mode) goto_phase(i2cram_pkg::PH_RSTART);
          else after_write_ack();
        end
      end
      i2cram_pkg::PH_DATA: if (send_bit_step()) goto_phase(i2cram_pkg::PH_DATA_ACK);
      i2cram_pkg::PH_DATA_ACK: begin
        if (ack_slot_step(sda)) begin
          if (bytes_to_go != 8'd0) bytes_to_go = bytes_to_go - 8'd1;
          after_write_ack();
        end
      end
      i2cram_pkg::PH_RSTART: begin
        if (start_cond_step()) begin
          goto_phase(i2cram_pkg::PH_RADDR);
          tx_shift = {dev_addr, 1'b1};
        end
      end
      i2cram_pkg::PH_RADDR: if (send_bit_step()) goto_phase(i2cram_pkg::PH_RADDR_ACK);
      i2cram_pkg::PH_RADDR_ACK: begin
        if (ack_slot_step(sda)) begin
          if (bytes_to_go != 8'd0) goto_phase(i2cram_pkg::PH_RECV);
          else goto_phase(i2cram_pkg::PH_STOP);
        end
      end
      i2cram_pkg::PH_RECV: begin
        case (sub_step)
          2'd0: begin
            sda_lvl  = 1'b1;
            rx_shift = 8'd0;
            bit_pos  = 3'd0;
            sub_step = 2'd1;
          end
          2'd1: begin
            scl_lvl  = 1'b1;
            sub_step = 2'd2;
          end
          default: begin
            if (sda) rx_shift[7 - bit_pos] = 1'b1;
            scl_lvl = 1'b0;
            if (bit_pos == 3'd7) begin
              step_flags.read_data  = rx_shift;
              step_flags.read_valid = 1'b1;
              step_flags.read_last  = (bytes_to_go == 8'd1);
              goto_phase(i2cram_pkg::PH_MACK);
            end else begin
              bit_pos  = bit_pos + 3'd1;
              sub_step = 2'd1;
            end
          end
        endcase
      end
      i2cram_pkg::PH_MACK: begin
        case (sub_step)
          2'd0: begin
            // nack on the final byte
            sda_lvl  = (bytes_to_go <= 8'd1);
            sub_step = 2'd1;
          end
          2'd1: begin
            scl_lvl  = 1'b1;
            sub_step = 2'd2;
          end
          default: begin
            scl_lvl = 1'b0;
            if (bytes_to_go != 8'd0) bytes_to_go = bytes_to_go - 8'd1;
            if (bytes_to_go != 8'd0) goto_phase(i2cram_pkg::PH_RECV);
            else goto_phase(i2cram_pkg::PH_STOP);
          end
        endcase
      end
      i2cram_pkg::PH_STOP: begin
        case (sub_step)
          2'd0: begin sda_lvl = 1'b0; sub_step = 2'd1; end
          2'd1: begin scl_lvl = 1'b1; sub_step = 2'd2; end
          default: begin
            sda_lvl = 1'b1;
            step_flags.done_res = 1'b1;
            goto_phase(i2cram_pkg::PH_IDLE);
          end
        endcase
      end
      default: goto_phase(i2cram_pkg::PH_IDLE);
    endcase
  endfunction

  function automatic i2cram_pkg::out_t line_state_after(i2cram_pkg::in_t b);
    i2cram_pkg::out_t r;
    step_flags = '0;
    if (b.action == i2cram_pkg::ACT_TICK) begin
      pin_tick(b.sda_in);
    end else if (b.action == i2cram_pkg::ACT_BYTE) begin
      if (seq_phase == i2cram_pkg::PH_WAIT) begin
        tx_shift  = b.write_data;
        tx_loaded = 1'b1;
      end
    end else if (seq_phase == i2cram_pkg::PH_IDLE) begin
      dev_addr    = b.device_address;
      reg_sel     = b.register_address;
      bytes_to_go = (int'(b.byte_count) > MAX_BURST) ? 8'(MAX_BURST) : b.byte_count;
      rd_mode     = (b.action == i2cram_pkg::ACT_READ);
      tx_loaded   = 1'b0;
      goto_phase(i2cram_pkg::PH_START);
    end
    r           = step_flags;
    r.scl_out   = scl_lvl;
    r.sda_out   = sda_lvl;
    r.busy_res  = (seq_phase != i2cram_pkg::PH_IDLE);
    r.want_byte = (seq_phase == i2cram_pkg::PH_WAIT) && !tx_loaded;
    return r;
  endfunction

  function automatic string show(i2cram_pkg::out_t r);
    return {$sformatf("scl=%b sda=%b busy=%b want=%b rdata=%02h ",
                      r.scl_out, r.sda_out, r.busy_res, r.want_byte, r.read_data),
            $sformatf("rv=%b rl=%b ack=%b av=%b done=%b",
                      r.read_valid, r.read_last, r.ack_sampled, r.ack_valid, r.done_res)};
  endfunction

  always @(posedge clk) begin : watch
    i2cram_pkg::out_t want;
    if (!rst_n) begin
      clear_sequencer();
      line_states.delete();
    end else begin
      // result side first: a beat taken now belongs to an older input
      if (out_valid && out_ready) begin
        if (line_states.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat: %s", show(out_data));
        end else begin
          want = line_states.pop_front();
          checks++;
          if (want.read_valid) rx_bytes++;
          if (want.done_res) stops++;
          if (out_data !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch on result %0d", checks);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(out_data));
            end
          end
        end
      end
      if (in_valid && in_ready) line_states.push_back(line_state_after(in_data));
    end
    fail_count    <= fails;
    waiting       <= line_states.size();
    checked_count <= checks;
    stop_count    <= stops;
    rx_byte_count <= rx_bytes;
  end

endmodule

// ----- tb/i2c_register_access_master_test.sv -----
`timescale 1ns / 1ps
module i2c_register_access_master_test;

  localparam int TOTAL_BEATS = 1400;
  // slowest run: ~1800 beats, each with a random input gap plus a random result stall
  localparam int CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  i2cram_pkg::in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  i2cram_pkg::out_t out_data;

  int fail_count;
  int waiting;
  int checked_count;
  int stop_count;
  int rx_byte_count;

  int beats_sent = 0;
  int cycle_cnt  = 0;
  // when set, the matching side runs back to back with no idle cycles
  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;

  i2c_register_access_master u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  i2c_register_access_master_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .waiting       (waiting),
    .checked_count (checked_count),
    .stop_count    (stop_count),
    .rx_byte_count (rx_byte_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycle_cnt, waiting);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall before each beat, held ready until one is taken
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // every field random, so unused bits toggle too
  function automatic i2cram_pkg::in_t any_beat(i2cram_pkg::act_t a);
    i2cram_pkg::in_t b;
    b.action           = a;
    b.device_address   = 7'($urandom);
    b.register_address = 8'($urandom);
    b.byte_count       = 8'($urandom);
    b.write_data       = 8'($urandom);
    b.sda_in           = 1'($urandom);
    return b;
  endfunction

  // valid drops only during a drawn gap; a zero gap keeps it high for the next beat
  task automatic push_beat(input i2cram_pkg::in_t b);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    beats_sent++;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // pin steps with random sampled sda; noisy runs sprinkle in beats the
  // sequencer should drop (begin while busy) or treat as a data refresh
  task automatic tick_run(input int n, input bit noisy);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0:       push_beat(any_beat(i2cram_pkg::ACT_BYTE));
          1:       push_beat(any_beat(i2cram_pkg::ACT_WRITE));
          default: push_beat(any_beat(i2cram_pkg::ACT_READ));
        endcase
      end
      push_beat(any_beat(i2cram_pkg::ACT_TICK));
    end
  endtask

  // idle traffic: ticks and data bytes with no transfer open
  task automatic idle_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) push_beat(any_beat(i2cram_pkg::ACT_TICK));
      else push_beat(any_beat(i2cram_pkg::ACT_BYTE));
    end
  endtask

  // one full transfer; pin step counts follow the bus framing:
  //   start 4, each byte 24 plus a 3-step ack slot, repeated start 4,
  //   received byte 17 plus a 3-step master ack, stop 3
  // rough = extra begin while busy, stalls waiting for data, data overwrites
  task automatic run_transfer(input i2cram_pkg::act_t op, input logic [6:0] dev,
                              input logic [7:0] rg, input logic [7:0] cnt,
                              input bit rough);
    i2cram_pkg::in_t b;
    in_steady  = ($urandom_range(0, 3) == 0);
    out_steady = ($urandom_range(0, 3) == 0);
    b = any_beat(op);
    b.device_address   = dev;
    b.register_address = rg;
    b.byte_count       = cnt;
    push_beat(b);
    if (rough) begin
      push_beat(any_beat(op == i2cram_pkg::ACT_WRITE ? i2cram_pkg::ACT_READ
                                                      : i2cram_pkg::ACT_WRITE));
    end
    // start, address with write bit, register byte
    tick_run(58, 1'b1);
    if (op == i2cram_pkg::ACT_READ) begin
      tick_run(31, 1'b1);
      tick_run(20 * int'(cnt), 1'b1);
    end else begin
      for (int i = 0; i < int'(cnt); i++) begin
        // ticks here find no data yet and must leave the pins alone
        if (rough || $urandom_range(0, 3) == 0) tick_run($urandom_range(1, 3), 1'b0);
        if (rough || $urandom_range(0, 7) == 0) push_beat(any_beat(i2cram_pkg::ACT_BYTE));
        push_beat(any_beat(i2cram_pkg::ACT_BYTE));
        tick_run(27, 1'b1);
      end
    end
    tick_run(3, 1'b1);
  endtask

  initial begin : stimulus
    i2cram_pkg::in_t  b;
    i2cram_pkg::act_t op;
    logic [7:0] cnt;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks with both sda levels and a stray data byte
    b = any_beat(i2cram_pkg::ACT_TICK);
    b.sda_in = 1'b0;
    push_beat(b);
    b.sda_in = 1'b1;
    push_beat(b);
    push_beat(any_beat(i2cram_pkg::ACT_BYTE));
    // address and register extremes, empty transfers both ways
    run_transfer(i2cram_pkg::ACT_WRITE, 7'h7F, 8'hFF, 8'd0, 1'b1);
    run_transfer(i2cram_pkg::ACT_READ, 7'h00, 8'h00, 8'd0, 1'b0);
    // write with data stalls and overwritten bytes, single-byte read (nack only)
    run_transfer(i2cram_pkg::ACT_WRITE, 7'h55, 8'hA5, 8'd2, 1'b1);
    run_transfer(i2cram_pkg::ACT_READ, 7'h2A, 8'h5A, 8'd1, 1'b1);
    // a longer read burst
    run_transfer(i2cram_pkg::ACT_READ, 7'($urandom), 8'($urandom), 8'd12, 1'b0);

    // random transfers, mostly short bursts
    while (beats_sent < TOTAL_BEATS) begin
      idle_noise($urandom_range(0, 2));
      op  = ($urandom_range(0, 1) == 0) ? i2cram_pkg::ACT_WRITE : i2cram_pkg::ACT_READ;
      cnt = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(4, 16)) : 8'($urandom_range(0, 3));
      run_transfer(op, 7'($urandom), 8'($urandom), cnt, $urandom_range(0, 5) == 0);
    end
    idle_noise(2);

    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d input beats and %0d checked result beats", beats_sent,
             checked_count);
    $display("%0d transfers ran to a stop, %0d bytes came back from reads", stop_count,
             rx_byte_count);
    if (fail_count == 0 && waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
